// ===== design/hidrf_pkg.sv =====
package hidrf_pkg;

    localparam int REPORT_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;

    // header lengths: channel, tag, sequence; first report adds the length word
    localparam int HDR_BYTES       = 5;
    localparam int HDR_BYTES_FIRST = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TAG = 2'd1;

    // header byte positions
    localparam logic [2:0] HB_CHAN_HI = 3'd0;
    localparam logic [2:0] HB_CHAN_LO = 3'd1;
    localparam logic [2:0] HB_TAG     = 3'd2;
    localparam logic [2:0] HB_SEQ_HI  = 3'd3;
    localparam logic [2:0] HB_SEQ_LO  = 3'd4;
    localparam logic [2:0] HB_LEN_HI  = 3'd5;
    localparam logic [2:0] HB_LEN_LO  = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] command_length;
    } hidrf_in_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       report_end;
        logic       run_last;
    } hidrf_out_t;

    // one classified command byte, handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] length;
        logic [15:0] seq;
        logic        first;
        logic        hdr;
        logic        last;
    } hidrf_desc_t;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_DATA,
        PH_PAD
    } hidrf_phase_t;

endpackage

// ===== design/hidrf_front.sv =====
module hidrf_front
    import hidrf_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  hidrf_in_t   in_data,
    output hidrf_desc_t desc
);

    localparam int PosW = $clog2(REPORT_BYTES);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [15:0]     seq_reg, seq_next;
    logic [15:0]     rem_reg, rem_next;

    logic            first;
    logic [15:0]     len_eff;
    logic [15:0]     rem_cur;
    logic [PosW-1:0] pos_cur;
    logic [15:0]     seq_cur;
    logic            hdr;
    logic            last;
    logic [PosW-1:0] hdr_len;
    logic [PosW-1:0] pos_data;
    logic [PosW-1:0] pos_after;

    always_comb begin
        first     = (rem_reg == 16'd0);
        len_eff   = (in_data.command_length == 16'd0) ? 16'd1 : in_data.command_length;
        rem_cur   = first ? len_eff : rem_reg;
        pos_cur   = first ? '0 : pos_reg;
        seq_cur   = first ? 16'd0 : seq_reg;
        hdr       = (pos_cur == '0);
        rem_next  = rem_cur - 16'd1;
        last      = (rem_next == 16'd0);
        hdr_len   = first ? PosW'(HDR_BYTES_FIRST) : PosW'(HDR_BYTES);
        pos_data  = pos_cur + (hdr ? hdr_len : '0);
        pos_after = (pos_data == PosW'(REPORT_BYTES - 1)) ? '0 : pos_data + 1'b1;
        // the last byte is padded out to the report boundary
        pos_next  = last ? '0 : pos_after;
        seq_next  = hdr ? seq_cur + 16'd1 : seq_cur;

        desc.data   = in_data.data_byte;
        desc.length = rem_cur;
        desc.seq    = seq_cur;
        desc.first  = first;
        desc.hdr    = hdr;
        desc.last   = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            seq_reg <= '0;
            rem_reg <= '0;
        end else if (in_fire) begin
            pos_reg <= pos_next;
            seq_reg <= seq_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== design/hidrf_fifo.sv =====
module hidrf_fifo
    import hidrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  hidrf_desc_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output hidrf_desc_t pop_data
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    hidrf_desc_t     mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != (PtrW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/hidrf_back.sv =====
module hidrf_back
    import hidrf_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  hidrf_desc_t           q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hidrf_out_t            m_data
);

    localparam int PosW = $clog2(REPORT_BYTES);

    logic [15:0]     chan_reg;
    logic [7:0]      tag_reg;

    hidrf_desc_t     cur_reg;
    logic            cur_vld_reg, cur_vld_next;
    hidrf_phase_t    phase_reg, phase_next;
    logic [2:0]      hidx_reg, hidx_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic            m_valid_reg, m_valid_next;
    hidrf_out_t      m_data_reg;

    logic            out_free;
    logic            pos_end;
    logic [2:0]      hdr_last;
    logic [7:0]      byte_sel;
    logic            done;
    logic            fire;
    logic            pop;

    assign out_free = !m_valid_reg || m_ready;
    assign pos_end  = (pos_reg == PosW'(REPORT_BYTES - 1));
    assign hdr_last = cur_reg.first ? HB_LEN_LO : HB_SEQ_LO;
    assign fire     = cur_vld_reg && out_free;
    // next item loads in the cycle the current one sends its final beat
    assign pop      = q_valid && (!cur_vld_reg || (fire && done));
    assign q_ready  = pop;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // outputs of the current phase
    always_comb begin
        byte_sel = 8'h00;
        done     = 1'b0;
        case (phase_reg)
            PH_HDR: begin
                case (hidx_reg)
                    HB_CHAN_HI: byte_sel = chan_reg[15:8];
                    HB_CHAN_LO: byte_sel = chan_reg[7:0];
                    HB_TAG:     byte_sel = tag_reg;
                    HB_SEQ_HI:  byte_sel = cur_reg.seq[15:8];
                    HB_SEQ_LO:  byte_sel = cur_reg.seq[7:0];
                    HB_LEN_HI:  byte_sel = cur_reg.length[15:8];
                    HB_LEN_LO:  byte_sel = cur_reg.length[7:0];
                    default:    byte_sel = 8'h00;
                endcase
                done = 1'b0;
            end
            PH_DATA: begin
                byte_sel = cur_reg.data;
                done     = !(cur_reg.last && !pos_end);
            end
            PH_PAD: begin
                byte_sel = 8'h00;
                done     = pos_end;
            end
            default: begin
                byte_sel = 8'h00;
                done     = 1'b0;
            end
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        if (pop) begin
            phase_next = q_data.hdr ? PH_HDR : PH_DATA;
            hidx_next  = HB_CHAN_HI;
        end else if (fire) begin
            case (phase_reg)
                PH_HDR: begin
                    if (hidx_reg == hdr_last) begin
                        phase_next = PH_DATA;
                    end else begin
                        hidx_next = hidx_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    if (!done) begin
                        phase_next = PH_PAD;
                    end
                end
                PH_PAD:  phase_next = PH_PAD;
                default: phase_next = PH_DATA;
            endcase
        end
    end

    always_comb begin
        cur_vld_next = cur_vld_reg;
        if (pop) begin
            cur_vld_next = 1'b1;
        end else if (fire && done) begin
            cur_vld_next = 1'b0;
        end
        pos_next = pos_reg;
        if (fire) begin
            pos_next = pos_end ? '0 : pos_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_data;
        end
        if (fire) begin
            m_data_reg.report_byte <= byte_sel;
            m_data_reg.report_end  <= pos_end;
            m_data_reg.run_last    <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg    <= 16'd257;
            tag_reg     <= 8'd5;
            cur_vld_reg <= 1'b0;
            phase_reg   <= PH_DATA;
            hidx_reg    <= HB_CHAN_HI;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CHANNEL_ID:  chan_reg <= cfg_wdata;
                    REG_COMMAND_TAG: tag_reg  <= cfg_wdata[7:0];
                    default:         ;
                endcase
            end
            cur_vld_reg <= cur_vld_next;
            phase_reg   <= phase_next;
            hidx_reg    <= hidx_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/hid_apdu_report_framer.sv =====
// channel  | dir | handshake         | beat
// s_       | in  | s_valid / s_ready | one command byte plus command length
// m_       | out | m_valid / m_ready | one report byte with end and last marks
// cfg_     | in  | cfg_wr_en         | channel word (0) or tag byte (1)
//
// a command byte leaves the back sequencer as one data beat, after a 5-byte header when
// it opens a report (7 bytes on the first report), with up to REPORT_BYTES-6 pad bytes
// after the final byte; the back emits one report byte per cycle while m_ready holds
// an accepted s_ byte passes the queue, the back's current-item register and the output register
// the front accepts one byte per cycle while the 4-deep queue has room
// synchronous active-low reset clears framing state and restores register defaults
module hid_apdu_report_framer
    import hidrf_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hidrf_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hidrf_out_t            m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    hidrf_desc_t front_desc;
    hidrf_desc_t q_data;
    logic        q_valid;
    logic        q_ready;
    logic        in_fire;

    assign in_fire = s_valid && s_ready;

    hidrf_front #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_data (s_data),
        .desc    (front_desc)
    );

    hidrf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    hidrf_back #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== design/hidrf_checker.sv =====
module hidrf_checker
    import hidrf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input hidrf_in_t             s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input hidrf_out_t            m_data,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a burst runs without gaps until its last beat
    a_burst_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("gap inside a result burst");

    // after idle, a first beat needs an input taken before it
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !$past(s_valid && s_ready) && !(s_valid && s_ready)
        && !$past(s_valid && s_ready, 2)
        && $past(!m_valid) |=> !m_valid || $past(m_valid))
        else $error("result appeared with no input behind it");

endmodule

bind hid_apdu_report_framer hidrf_checker u_chk (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hidrf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum {ROW_CFG, ROW_BYTE} row_kind_t;
    // how a directed row is checked: by the predictor, as a byte passing straight
    // through mid-report, or as a one-byte command making a single padded report
    typedef enum {EXP_PREDICT, EXP_PASS, EXP_SOLO} exp_form_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    wdata;
        logic [7:0]               d;
        logic [15:0]              l;
        exp_form_t                form;
        logic [55:0]              hdr;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    hidrf_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    hidrf_out_t            m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    hid_apdu_report_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // framing state mirrored on the testbench side
    logic [15:0] chan_word = 16'h0101;
    logic [7:0]  tag_byte  = 8'h05;
    int          rpt_pos   = 0;
    logic [15:0] rpt_seq   = 16'h0000;
    logic [15:0] cmd_left  = 16'h0000;

    hidrf_out_t  frame_beats[$];
    hidrf_out_t  pending_report_beats[$];
    hidrf_out_t  exp_beat;
    dir_row_t    dir_rows[$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int err_count     = 0;
    int bytes_sent    = 0;
    int cmds_opened   = 0;
    int beats_checked = 0;
    int reports_seen  = 0;
    int cfg_writes    = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void queue_expect(input hidrf_out_t b);
        pending_report_beats.insert(pending_report_beats.size(), b);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        hidrf_out_t o;
        o.report_byte = b;
        o.report_end  = (rpt_pos == REPORT_BYTES_DEF - 1);
        o.run_last    = 1'b0;
        frame_beats.insert(frame_beats.size(), o);
        rpt_pos = o.report_end ? 0 : rpt_pos + 1;
    endfunction

    function automatic void frame_byte(input logic [7:0] d, input logic [15:0] l);
        logic opening;
        frame_beats.delete();
        opening = (cmd_left == 16'h0000);
        if (opening) begin
            cmd_left = (l == 16'h0000) ? 16'h0001 : l;
            rpt_seq  = 16'h0000;
            rpt_pos  = 0;
            cmds_opened++;
        end
        if (rpt_pos == 0) begin
            put_byte(chan_word[15:8]);
            put_byte(chan_word[7:0]);
            put_byte(tag_byte);
            put_byte(rpt_seq[15:8]);
            put_byte(rpt_seq[7:0]);
            if (opening) begin
                put_byte(cmd_left[15:8]);
                put_byte(cmd_left[7:0]);
            end
            rpt_seq = rpt_seq + 16'h0001;
        end
        put_byte(d);
        cmd_left = cmd_left - 16'h0001;
        if (cmd_left == 16'h0000) begin
            while (rpt_pos != 0 && frame_beats.size() < REPORT_BYTES_DEF)
                put_byte(8'h00);
        end
        frame_beats[frame_beats.size() - 1].run_last = 1'b1;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '{ROW_CFG, idx, val, 8'h00, 16'h0000, EXP_PREDICT, 56'h0};
        return r;
    endfunction

    function automatic dir_row_t byte_row(input logic [7:0] d, input logic [15:0] l,
                                          input exp_form_t form, input logic [55:0] hdr);
        dir_row_t r;
        r = '{ROW_BYTE, REG_CHANNEL_ID, 16'h0000, d, l, form, hdr};
        return r;
    endfunction

    function automatic logic [15:0] pick_word(input logic [15:0] top);
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return top;
            default: return 16'($urandom_range(0, int'(top)));
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1, 2, 3: return 16'($urandom_range(1, 6));
            4:       return 16'd57;          // first report exactly full
            5:       return 16'd116;         // second report exactly full
            6:       return 16'($urandom_range(55, 60));
            7:       return 16'($urandom_range(7, 130));
            8:       return 16'($urandom_range(1, 2));
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic void set_pressure(input int mix);
        case (mix)
            0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1:       begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
            2:       begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
            default: begin snd_idle_pct = 13; rcv_stall_pct = 13; end
        endcase
    endfunction

    // returns at the edge where the beat is taken
    task automatic drive_beat(input logic [7:0] d, input logic [15:0] l);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        s_valid   <= 1'b1;
        s_data    <= '{data_byte: d, command_length: l};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic [15:0] l);
        drive_beat(d, l);
        frame_byte(d, l);
        foreach (frame_beats[k]) queue_expect(frame_beats[k]);
    endtask

    // registers only change once every report beat has drained
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        while (pending_report_beats.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CHANNEL_ID:  chan_word = val;
            REG_COMMAND_TAG: tag_byte  = val[7:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_report_beats.size() == 0) begin
                err_count++;
                $display("%0t: expected no beat, got byte %02h end %0b last %0b", $time,
                         m_data.report_byte, m_data.report_end, m_data.run_last);
            end else begin
                exp_beat = pending_report_beats.pop_front();
                if (m_data.report_byte !== exp_beat.report_byte ||
                    m_data.report_end !== exp_beat.report_end ||
                    m_data.run_last !== exp_beat.run_last) begin
                    err_count++;
                    $display("%0t: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/end/last)",
                             $time, exp_beat.report_byte, exp_beat.report_end,
                             exp_beat.run_last, m_data.report_byte,
                             m_data.report_end, m_data.run_last);
                end
                beats_checked++;
                if (m_data.report_end) reports_seen++;
            end
        end
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    initial begin
        hidrf_out_t beat;
        int         r;
        int         i;
        int         ph;

        // reset values show in the first header
        add_row(byte_row(8'h00, 16'h0000, EXP_SOLO, 56'h0101_05_0000_0001));
        add_row(byte_row(8'hFF, 16'h0001, EXP_SOLO, 56'h0101_05_0000_0001));
        add_row(byte_row(8'hA5, 16'h0003, EXP_PREDICT, 56'h0));
        // length is ignored past the first byte
        add_row(byte_row(8'h5A, 16'hFFFF, EXP_PASS, 56'h0));
        add_row(byte_row(8'h3C, 16'h0000, EXP_PREDICT, 56'h0));
        add_row(cfg_row(REG_CHANNEL_ID, 16'hFFFF));
        add_row(cfg_row(REG_COMMAND_TAG, 16'h00FF));
        add_row(byte_row(8'h81, 16'h0001, EXP_SOLO, 56'hFFFF_FF_0000_0001));
        add_row(cfg_row(REG_CHANNEL_ID, 16'h0000));
        add_row(cfg_row(REG_COMMAND_TAG, 16'h0000));
        add_row(byte_row(8'h7E, 16'h0002, EXP_PREDICT, 56'h0));
        add_row(byte_row(8'h00, 16'h8000, EXP_PREDICT, 56'h0));
        // writes to unmapped indexes leave both registers alone
        add_row(cfg_row(REG_UNUSED_2, 16'h1234));
        add_row(cfg_row(REG_UNUSED_3, 16'hABCD));
        add_row(byte_row(8'h42, 16'h0001, EXP_SOLO, 56'h0000_00_0000_0001));
        add_row(cfg_row(REG_CHANNEL_ID, 16'hA55A));
        add_row(cfg_row(REG_COMMAND_TAG, 16'hC396));
        add_row(byte_row(8'h11, 16'h0000, EXP_SOLO, 56'hA55A_96_0000_0001));
        add_row(cfg_row(REG_CHANNEL_ID, 16'h0101));
        add_row(cfg_row(REG_COMMAND_TAG, 16'h0005));
        add_row(byte_row(8'h99, 16'h0004, EXP_PREDICT, 56'h0));
        add_row(byte_row(8'h01, 16'hFFFF, EXP_PASS, 56'h0));
        add_row(byte_row(8'h80, 16'h0000, EXP_PASS, 56'h0));
        add_row(byte_row(8'hFE, 16'h0001, EXP_PREDICT, 56'h0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_pressure(3);
        for (r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                cfg_write(dir_rows[r].idx, dir_rows[r].wdata);
            end else if (dir_rows[r].form == EXP_PREDICT) begin
                send_byte(dir_rows[r].d, dir_rows[r].l);
            end else begin
                drive_beat(dir_rows[r].d, dir_rows[r].l);
                frame_byte(dir_rows[r].d, dir_rows[r].l);
                if (dir_rows[r].form == EXP_PASS) begin
                    beat = '{report_byte: dir_rows[r].d, report_end: 1'b0, run_last: 1'b1};
                    queue_expect(beat);
                end else begin
                    for (i = 0; i < REPORT_BYTES_DEF; i++) begin
                        if (i < 7)
                            beat.report_byte = dir_rows[r].hdr[55 - 8*i -: 8];
                        else
                            beat.report_byte = (i == 7) ? dir_rows[r].d : 8'h00;
                        beat.report_end = (i == REPORT_BYTES_DEF - 1);
                        beat.run_last   = (i == REPORT_BYTES_DEF - 1);
                        queue_expect(beat);
                    end
                end
            end
        end

        // random commands; a command may straddle a register change
        for (ph = 0; ph < 7; ph++) begin
            set_pressure(ph % 4);
            cfg_write(REG_CHANNEL_ID, pick_word(16'hFFFF));
            cfg_write(REG_COMMAND_TAG, {8'($urandom_range(255)), 8'(pick_word(16'h00FF))});
            if ($urandom_range(3) == 0)
                cfg_write($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          16'($urandom_range(65535)));
            repeat (54) begin
                send_byte(8'($urandom_range(255)),
                          (cmd_left == 16'h0000) ? pick_length()
                                                 : 16'($urandom_range(65535)));
            end
        end

        // longest length word; the command is left open after its second header
        set_pressure(0);
        cfg_write(REG_CHANNEL_ID, 16'h0101);
        cfg_write(REG_COMMAND_TAG, 16'h0005);
        while (cmd_left != 16'h0000)
            send_byte(8'($urandom_range(255)), 16'($urandom_range(65535)));
        send_byte(8'($urandom_range(255)), 16'hFFFF);
        repeat (69) send_byte(8'($urandom_range(255)), 16'($urandom_range(65535)));

        s_valid <= 1'b0;
        rcv_stall_pct = 0;
        while (pending_report_beats.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("framed %0d command bytes from %0d commands into %0d beats, %0d full reports",
                 bytes_sent, cmds_opened, beats_checked, reports_seen);
        $display("%0d register writes across four sender/receiver pressure mixes", cfg_writes);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
